### design/triplanar_blend_weights_assert.svh
// Assertion macros for the triplanar blend weights block.
// They rely on signals named clock and reset in the module that uses them.
`ifndef TRIPLANAR_BLEND_WEIGHTS_ASSERT_SVH
`define TRIPLANAR_BLEND_WEIGHTS_ASSERT_SVH

// Consequent holds in the same cycle.
`define TRBW_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the next cycle.
`define TRBW_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### design/trbw_pkg.sv
`default_nettype none
package trbw_pkg;

   localparam int LOG_STEPS  = 16;
   localparam int EXP_STEPS  = 16;
   localparam int DIV_BITS   = 17;
   localparam int LOG_LAT    = LOG_STEPS + 1;
   localparam int EXP_LAT    = EXP_STEPS + 3;
   localparam int DIV_LAT    = DIV_BITS + 1;
   localparam int PIPE_DEPTH = 1 + LOG_LAT + 1 + EXP_LAT + 1 + DIV_LAT;
   localparam int E_STAGES   = 4;

   localparam int ADDR_W = 3;
   localparam logic REG_TW   = 1'b0;
   localparam logic REG_SKIP = 1'b1;
   localparam logic [15:0] TW_RESET   = 16'd0;
   localparam logic [15:0] SKIP_RESET = 16'd33;

   typedef struct packed {
      logic [1:0] sel;
      logic [2:0] zero;
   } side_type;

   typedef struct packed {
      logic [2:0][15:0] weight;
      logic [2:0]       skip;
      logic             degenerate;
   } result_type;

   function automatic logic [16:0] magnitude(input logic [15:0] n);
      logic [16:0] ext;
      ext = {n[15], n};
      return n[15] ? (~ext + 17'd1) : ext;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] rem;
      logic [63:0] bit_v;
      res   = 64'd0;
      rem   = v;
      bit_v = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (bit_v > v) bit_v = bit_v >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bit_v != 64'd0) begin
            if (rem >= res + bit_v) begin
               rem = rem - res - bit_v;
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res;
   endfunction

   // 2^(-2^-k) in Q0.30
   function automatic logic [29:0] exp_root(input int k);
      logic [63:0] c;
      c = isqrt64(64'd1 << 59);
      for (int j = 2; j <= 16; j++) begin
         if (j <= k) c = isqrt64(c << 30);
      end
      return c[29:0];
   endfunction

endpackage
`default_nettype wire

### design/trbw_if.sv
`default_nettype none
interface trbw_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   modport source(output valid, output normal_x, output normal_y, output normal_z,
                  input ready);
   modport sink(input valid, input normal_x, input normal_y, input normal_z,
                output ready);
endinterface

interface trbw_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] weight_x;
   logic [15:0] weight_y;
   logic [15:0] weight_z;
   logic        skip_x;
   logic        skip_y;
   logic        skip_z;
   logic        degenerate;
   modport source(output valid, output weight_x, output weight_y, output weight_z,
                  output skip_x, output skip_y, output skip_z, output degenerate,
                  input ready);
   modport sink(input valid, input weight_x, input weight_y, input weight_z,
                input skip_x, input skip_y, input skip_z, input degenerate,
                output ready);
endinterface
`default_nettype wire

### design/triplanar_blend_weights.sv
// Each accepted transaction yields one result on rsp_if, via a two-entry queue.
// Throughput: one transaction per cycle unless a full result queue stalls it;
// three lanes run log2, 2^-q and the divide side by side, each a fully
// pipelined chain of one step per stage. Synchronous reset clears valid state
// and the result queue and loads transition_width = 0, skip_threshold = 33.
`default_nettype none
`include "triplanar_blend_weights_assert.svh"
module triplanar_blend_weights (
   input  wire logic                            clock,
   input  wire logic                            reset,
   trbw_req_if.sink                             req_if,
   trbw_rsp_if.source                           rsp_if,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [trbw_pkg::ADDR_W-1:0]     paddr,
   input  wire logic [31:0]                     pwdata,
   output logic      [31:0]                     prdata,
   output logic                                 pready
);
   localparam int D  = trbw_pkg::PIPE_DEPTH;
   localparam int LL = trbw_pkg::LOG_LAT;
   localparam int NE = trbw_pkg::E_STAGES;

   logic [15:0] tw_ff, thr_ff;
   logic [16:0] t_in, t_ff;
   logic [16:0] p_ff [0:NE];
   logic [23:0] m195;
   logic [22:0] e_ff;

   logic                 adv, accept, push, pop;
   logic [D-1:0]         vld_ff;
   logic                 degen_ff [0:D-1];
   trbw_pkg::side_type   side_ff  [0:LL];
   trbw_pkg::side_type   side_in;
   logic [16:0]          a_in  [3];
   logic [16:0]          a_ff  [3];
   logic [19:0]          lg    [3];
   logic [19:0]          lm;
   logic [19:0]          d_ff  [3];
   logic                 dz_ff [3];
   logic [30:0]          v     [3];
   logic [30:0]          v_ff  [3];
   logic [31:0]          s_ff;
   logic [16:0]          quo   [3];

   trbw_pkg::result_type res_in;
   trbw_pkg::result_type q_mem [2];
   logic                 wr_ff, rd_ff;
   logic [1:0]           cnt_ff;

   // configuration
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tw_ff  <= trbw_pkg::TW_RESET;
         thr_ff <= trbw_pkg::SKIP_RESET;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == trbw_pkg::REG_TW) tw_ff <= pwdata[15:0];
         else thr_ff <= pwdata[15:0];
      end
   end
   assign prdata = (paddr[2] == trbw_pkg::REG_SKIP) ? {16'd0, thr_ff} : {16'd0, tw_ff};

   // exponent e = 2.5 + 97.5*(1-w)^5, Q7.16
   assign t_in = 17'h10000 - {1'b0, tw_ff};
   assign m195 = {7'd0, p_ff[NE]} * 24'd195;
   always_ff @(posedge clock) begin
      t_ff    <= t_in;
      p_ff[0] <= t_in;
      for (int k = 1; k <= NE; k++) begin
         p_ff[k] <= 17'((({17'd0, p_ff[k-1]} * {17'd0, t_ff}) + 34'd32768) >> 16);
      end
      e_ff <= 23'd163840 + 23'((m195 + 24'd1) >> 1);
   end

   // handshake
   assign pop    = rsp_if.valid && rsp_if.ready;
   assign adv    = (cnt_ff != 2'd2) || pop;
   assign accept = req_if.valid && adv;
   assign push   = adv && vld_ff[D-1];
   assign req_if.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[D-2:0], accept};
   end

   // front stage
   assign a_in[0] = trbw_pkg::magnitude(req_if.normal_x);
   assign a_in[1] = trbw_pkg::magnitude(req_if.normal_y);
   assign a_in[2] = trbw_pkg::magnitude(req_if.normal_z);

   always_comb begin
      logic [16:0] m;
      m = a_in[0];
      side_in.sel = 2'd0;
      if (a_in[1] > m) begin
         m = a_in[1];
         side_in.sel = 2'd1;
      end
      if (a_in[2] > m) side_in.sel = 2'd2;
      for (int i = 0; i < 3; i++) side_in.zero[i] = (a_in[i] == 17'd0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) a_ff[i] <= a_in[i];
         side_ff[0]  <= side_in;
         degen_ff[0] <= &side_in.zero;
         for (int k = 1; k <= LL; k++) side_ff[k] <= side_ff[k-1];
         for (int k = 1; k < D; k++) degen_ff[k] <= degen_ff[k-1];
      end
   end

   // log2 lanes
   for (genvar g = 0; g < 3; g++) begin : g_log
      trbw_log2_lane u_log (
         .clock (clock),
         .en    (adv),
         .a     (a_ff[g]),
         .log_q (lg[g])
      );
   end

   // difference to the largest component
   always_comb begin
      unique case (side_ff[LL].sel)
         2'd0:    lm = lg[0];
         2'd1:    lm = lg[1];
         2'd2:    lm = lg[2];
         default: lm = lg[0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            d_ff[i]  <= lm - lg[i];
            dz_ff[i] <= side_ff[LL].zero[i];
         end
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_exp
      trbw_exp2_lane u_exp (
         .clock (clock),
         .en    (adv),
         .d     (d_ff[g]),
         .zero  (dz_ff[g]),
         .e     (e_ff),
         .v     (v[g])
      );
   end

   // merge: sum of lane powers
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) v_ff[i] <= v[i];
         s_ff <= {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_div
      trbw_div_lane u_div (
         .clock (clock),
         .en    (adv),
         .v     (v_ff[g]),
         .s     (s_ff),
         .quo   (quo[g])
      );
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (degen_ff[D-1]) res_in.weight[i] = 16'd0;
         else if (quo[i][16]) res_in.weight[i] = 16'hFFFF;
         else res_in.weight[i] = quo[i][15:0];
         res_in.skip[i] = res_in.weight[i] < thr_ff;
      end
      res_in.degenerate = degen_ff[D-1];
   end

   // two-entry result queue
   always_ff @(posedge clock) begin
      if (push) q_mem[wr_ff] <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign rsp_if.valid      = (cnt_ff != 2'd0);
   assign rsp_if.weight_x   = q_mem[rd_ff].weight[0];
   assign rsp_if.weight_y   = q_mem[rd_ff].weight[1];
   assign rsp_if.weight_z   = q_mem[rd_ff].weight[2];
   assign rsp_if.skip_x     = q_mem[rd_ff].skip[0];
   assign rsp_if.skip_y     = q_mem[rd_ff].skip[1];
   assign rsp_if.skip_z     = q_mem[rd_ff].skip[2];
   assign rsp_if.degenerate = q_mem[rd_ff].degenerate;

   `TRBW_ASSERT_NOW(a_no_overflow, push, (cnt_ff != 2'd2) || pop, "result queue overflow")
   `TRBW_ASSERT_NOW(a_degen_zero, rsp_if.valid && rsp_if.degenerate, (rsp_if.weight_x == 16'd0) && (rsp_if.weight_y == 16'd0) && (rsp_if.weight_z == 16'd0), "degenerate result with nonzero weight")
   `TRBW_ASSERT_NEXT(a_accept_enters, accept, vld_ff[0], "accepted transaction lost at entry")
endmodule
`default_nettype wire

### design/trbw_log2_lane.sv
`default_nettype none
module trbw_log2_lane (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [16:0] a,
   output logic      [19:0] log_q
);
   localparam int N = trbw_pkg::LOG_STEPS;

   logic [30:0] x_ff    [0:N];
   logic [15:0] frac_ff [0:N];
   logic [3:0]  pos_ff  [0:N];
   logic [3:0]  pos;
   logic [30:0] x_in;

   always_comb begin
      pos = 4'd0;
      for (int i = 1; i < 16; i++) begin
         if (a[i]) pos = 4'(i);
      end
   end

   assign x_in = {14'd0, a} << (5'd30 - {1'b0, pos});

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x_in;
         frac_ff[0] <= 16'd0;
         pos_ff[0]  <= pos;
      end
   end

   for (genvar k = 1; k <= N; k++) begin : g_step
      logic [61:0] sq;
      logic [31:0] y;
      assign sq = x_ff[k-1] * x_ff[k-1];
      assign y  = sq[61:30];
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]    <= y[31] ? y[31:1] : y[30:0];
            frac_ff[k] <= {frac_ff[k-1][14:0], y[31]};
            pos_ff[k]  <= pos_ff[k-1];
         end
      end
   end

   assign log_q = {pos_ff[N], frac_ff[N]};
endmodule
`default_nettype wire

### design/trbw_exp2_lane.sv
`default_nettype none
module trbw_exp2_lane (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [19:0] d,
   input  wire logic        zero,
   input  wire logic [22:0] e,
   output logic      [30:0] v
);
   localparam int N = trbw_pkg::EXP_STEPS;

   logic [35:0] pl_ff;
   logic [19:0] d_ff;
   logic [6:0]  eh_ff;
   logic        zero_ff;
   logic [26:0] ph;
   logic [42:0] tot;
   logic [26:0] q;
   logic [10:0] ip;
   logic [30:0] r_ff    [0:N];
   logic [15:0] f_ff    [0:N];
   logic [4:0]  sh_ff   [0:N];
   logic        kill_ff [0:N];
   logic [30:0] v_ff;

   // split e*d so each multiply stays narrow
   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff   <= e[15:0] * d;
         d_ff    <= d;
         eh_ff   <= e[22:16];
         zero_ff <= zero;
      end
   end

   assign ph  = eh_ff * d_ff;
   assign tot = {ph, 16'd0} + {7'd0, pl_ff} + 43'd32768;
   assign q   = tot[42:16];
   assign ip  = q[26:16];

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]    <= 31'h4000_0000;
         f_ff[0]    <= q[15:0];
         sh_ff[0]   <= ip[4:0];
         kill_ff[0] <= zero_ff || (ip >= 11'd31);
      end
   end

   for (genvar k = 1; k <= N; k++) begin : g_step
      localparam logic [29:0] CK = trbw_pkg::exp_root(k);
      logic [60:0] prod;
      logic [60:0] rnd;
      assign prod = r_ff[k-1] * CK;
      assign rnd  = prod + 61'd536870912;
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k]    <= f_ff[k-1][N-k] ? rnd[60:30] : r_ff[k-1];
            f_ff[k]    <= f_ff[k-1];
            sh_ff[k]   <= sh_ff[k-1];
            kill_ff[k] <= kill_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) v_ff <= kill_ff[N] ? 31'd0 : (r_ff[N] >> sh_ff[N]);
   end

   assign v = v_ff;
endmodule
`default_nettype wire

### design/trbw_div_lane.sv
`default_nettype none
module trbw_div_lane (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [30:0] v,
   input  wire logic [31:0] s,
   output logic      [16:0] quo
);
   localparam int N = trbw_pkg::DIV_BITS;

   logic [47:0] rem_ff [0:N];
   logic [31:0] s_ff   [0:N];
   logic [16:0] quo_ff [0:N];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {1'b0, v, 16'd0} + {17'd0, s[31:1]};
         s_ff[0]   <= s;
         quo_ff[0] <= 17'd0;
      end
   end

   for (genvar j = 1; j <= N; j++) begin : g_bit
      logic [47:0] dv;
      logic        ge;
      assign dv = {16'd0, s_ff[j-1]} << (N - j);
      assign ge = rem_ff[j-1] >= dv;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= ge ? (rem_ff[j-1] - dv) : rem_ff[j-1];
            s_ff[j]   <= s_ff[j-1];
            quo_ff[j] <= {quo_ff[j-1][15:0], ge};
         end
      end
   end

   assign quo = quo_ff[N];
endmodule
`default_nettype wire

### tb/tb.sv
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] weight [3];
      logic        skip [3];
      logic        degen;
   } blend_result_type;

   typedef struct {
      logic signed [15:0] n [3];
      bit                 typed;
      blend_result_type   want;
   } normal_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [trbw_pkg::ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   trbw_req_if req_if();
   trbw_rsp_if rsp_if();

   triplanar_blend_weights u_top (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #4 clock = ~clock;

   logic [15:0] cur_width = trbw_pkg::TW_RESET;
   logic [15:0] cur_skip = trbw_pkg::SKIP_RESET;
   logic [63:0] half_roots [17];
   blend_result_type pending_weights [$];
   int unsigned fail_count = 0;
   bit idle_on = 1'b0;
   bit quiet = 1'b0;
   int unsigned rsp_stall = 0;

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] trial;
      res = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = res | (64'd1 << b);
         if (trial * trial <= v) res = trial;
      end
      return res;
   endfunction

   function automatic logic [63:0] log2_fix(input logic [63:0] a);
      int pos;
      logic [63:0] x;
      logic [63:0] frac;
      pos = 0;
      frac = 0;
      while (pos < 15 && (a >> (pos + 1)) != 0) pos++;
      x = a << (30 - pos);
      for (int i = 0; i < 16; i++) begin
         x = (x * x) >> 30;
         frac = frac << 1;
         if (x >= (64'd1 << 31)) begin
            frac = frac | 1;
            x = x >> 1;
         end
      end
      return (64'(pos) << 16) | frac;
   endfunction

   function automatic logic [63:0] pow2_neg(input logic [63:0] q);
      logic [63:0] ip;
      logic [63:0] r;
      ip = q >> 16;
      r = 64'd1 << 30;
      if (ip >= 31) return 0;
      for (int k = 1; k <= 16; k++) begin
         if (q[16-k]) r = (r * half_roots[k] + (64'd1 << 29)) >> 30;
      end
      return r >> ip;
   endfunction

   function automatic blend_result_type blend_weights(input logic signed [15:0] n [3]);
      blend_result_type res;
      logic [63:0] a [3];
      logic [63:0] v [3];
      logic [63:0] t, p, e, m, lm, s, r;
      for (int i = 0; i < 3; i++) begin
         a[i] = n[i][15] ? 64'(17'h10000 - {1'b0, n[i]}) & 64'h1FFFF : 64'(n[i][14:0]);
         res.weight[i] = 0;
      end
      res.degen = (a[0] == 0 && a[1] == 0 && a[2] == 0);
      if (!res.degen) begin
         t = 65536 - 64'(cur_width);
         p = t;
         for (int i = 0; i < 4; i++) p = (p * t + 32768) >> 16;
         e = 163840 + ((195 * p + 1) >> 1);
         m = a[0];
         if (a[1] > m) m = a[1];
         if (a[2] > m) m = a[2];
         lm = log2_fix(m);
         s = 0;
         for (int i = 0; i < 3; i++) begin
            v[i] = (a[i] == 0) ? 0 : pow2_neg((e * (lm - log2_fix(a[i])) + 32768) >> 16);
            s += v[i];
         end
         for (int i = 0; i < 3; i++) begin
            r = (s != 0) ? (v[i] * 65536 + s / 2) / s : 0;
            res.weight[i] = (r > 65535) ? 16'hFFFF : r[15:0];
         end
      end
      for (int i = 0; i < 3; i++) res.skip[i] = res.weight[i] < cur_skip;
      return res;
   endfunction

   task automatic csr_write(input logic reg_idx, input logic [15:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {reg_idx, 2'b00};
      pwdata <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (reg_idx == trbw_pkg::REG_TW) cur_width = value;
      else cur_skip = value;
   endtask

   task automatic drain();
      while (pending_weights.size() != 0) @(posedge clock);
      repeat (trbw_pkg::PIPE_DEPTH + 5) @(posedge clock);
   endtask

   task automatic send_normal(input logic signed [15:0] n [3], input bit typed,
                              input blend_result_type want);
      blend_result_type pred;
      if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.normal_x <= n[0];
      req_if.normal_y <= n[1];
      req_if.normal_z <= n[2];
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      pred = typed ? want : blend_weights(n);
      pending_weights.push_back(pred);
   endtask

   function automatic logic signed [15:0] rand_comp(input int mode);
      unique case (mode)
         0: return 16'($urandom_range(0, 65535));
         1: return 16'sd0;
         2: return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
         3: return 16'(int'($urandom_range(0, 64)) * ($urandom_range(0, 1) ? 1 : -1));
         default: return 16'(int'($urandom_range(16000, 32767)) *
                             ($urandom_range(0, 1) ? 1 : -1));
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset || quiet || !idle_on) begin
         rsp_if.ready <= 1'b1;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= $urandom_range(0, 3);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      blend_result_type exp_w;
      logic [15:0] got_w [3];
      logic got_s [3];
      string ax;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got_w = '{rsp_if.weight_x, rsp_if.weight_y, rsp_if.weight_z};
         got_s = '{rsp_if.skip_x, rsp_if.skip_y, rsp_if.skip_z};
         if (pending_weights.size() == 0) begin
            $error("unexpected transaction on rsp");
            fail_count++;
         end else begin
            exp_w = pending_weights.pop_front();
            for (int i = 0; i < 3; i++) begin
               ax = (i == 0) ? "x" : (i == 1) ? "y" : "z";
               if (got_w[i] !== exp_w.weight[i]) begin
                  $error("weight_%s: expected %0d, got %0d", ax, exp_w.weight[i], got_w[i]);
                  fail_count++;
               end
               if (got_s[i] !== exp_w.skip[i]) begin
                  $error("skip_%s: expected %0d, got %0d", ax, exp_w.skip[i], got_s[i]);
                  fail_count++;
               end
            end
            if (rsp_if.degenerate !== exp_w.degen) begin
               $error("degenerate: expected %0d, got %0d", exp_w.degen, rsp_if.degenerate);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #3000000;
      $display("FAIL");
      $finish;
   end

   initial begin
      normal_row_type rows [$];
      normal_row_type row;
      blend_result_type none;
      blend_result_type axis_hit;
      logic signed [15:0] n [3];
      logic [15:0] tw_set [5];
      logic [15:0] sk_set [5];
      int total;
      int mode;

      req_if.valid = 1'b0;
      req_if.normal_x = '0;
      req_if.normal_y = '0;
      req_if.normal_z = '0;
      rsp_if.ready = 1'b1;
      for (int k = 0; k < 17; k++) half_roots[k] = 0;
      half_roots[1] = int_sqrt(64'd1 << 59);
      for (int k = 2; k <= 16; k++) half_roots[k] = int_sqrt(half_roots[k-1] << 30);

      none.weight = '{0, 0, 0};
      none.skip = '{1, 1, 1};
      none.degen = 1'b1;
      row.typed = 1'b1;
      row.n = '{0, 0, 0};
      row.want = none;
      rows.push_back(row);
      for (int ax = 0; ax < 3; ax++) begin
         axis_hit.weight = '{0, 0, 0};
         axis_hit.weight[ax] = 16'hFFFF;
         axis_hit.skip = '{1, 1, 1};
         axis_hit.skip[ax] = 1'b0;
         axis_hit.degen = 1'b0;
         row.want = axis_hit;
         row.n = '{0, 0, 0};
         row.n[ax] = 16'sh7FFF;
         rows.push_back(row);
         row.n[ax] = 16'sh8000;
         rows.push_back(row);
         row.n[ax] = 16'sd1;
         rows.push_back(row);
      end
      row.typed = 1'b0;
      row.n = '{-1, -1, -1};              rows.push_back(row);
      row.n = '{32767, 32767, 32767};     rows.push_back(row);
      row.n = '{-32768, 32767, 1};        rows.push_back(row);
      row.n = '{1, 1, 32767};             rows.push_back(row);
      row.n = '{18918, 18918, 18918};     rows.push_back(row);
      row.n = '{23170, 23170, 0};         rows.push_back(row);
      row.n = '{-23170, 16384, -9000};    rows.push_back(row);
      row.n = '{100, -200, 300};          rows.push_back(row);
      row.n = '{-32768, -32768, -32768};  rows.push_back(row);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (10) @(posedge clock);

      foreach (rows[i]) send_normal(rows[i].n, rows[i].typed, rows[i].want);
      req_if.valid <= 1'b0;
      drain();

      tw_set = '{16'hFFFF, 16'd0, 16'd32768, 16'($urandom), 16'd0};
      sk_set = '{16'd0, 16'hFFFF, 16'd1000, 16'($urandom), trbw_pkg::SKIP_RESET};
      total = 0;
      for (int ph = 0; ph < 5; ph++) begin
         csr_write(trbw_pkg::REG_TW, tw_set[ph]);
         csr_write(trbw_pkg::REG_SKIP, sk_set[ph]);
         repeat (10) @(posedge clock);
         idle_on = (ph != 2);
         for (int i = 0; i < 170; i++) begin
            if (total >= 740) quiet = 1'b1;
            if (ph == 1 && i == 85) begin
               req_if.valid <= 1'b0;
               while (pending_weights.size() != 0) @(posedge clock);
            end
            mode = $urandom_range(0, 9);
            for (int c = 0; c < 3; c++) begin
               if (mode < 4) n[c] = rand_comp(0);
               else n[c] = rand_comp($urandom_range(0, 4));
            end
            send_normal(n, 1'b0, none);
            total++;
         end
         req_if.valid <= 1'b0;
         drain();
      end

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

### files.f
+incdir+design
design/trbw_pkg.sv
design/trbw_if.sv
design/trbw_log2_lane.sv
design/trbw_exp2_lane.sv
design/trbw_div_lane.sv
design/triplanar_blend_weights.sv
tb/tb.sv
